// ----- rtl/rbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and field tables for the record batch v2 parser.
// No dependencies; imported by every module of the block.
package rbp_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam int RSP_DEPTH       = 8;
   localparam int RSP_PTR_W       = $clog2(RSP_DEPTH);
   localparam int MAX_RES         = 3;

   // parse phases, one per header field, record field or payload run
   typedef enum logic [4:0] {
      PH_BASE_OFFSET    = 5'd0,
      PH_BATCH_LEN      = 5'd1,
      PH_LEADER_EPOCH   = 5'd2,
      PH_MAGIC          = 5'd3,
      PH_CRC            = 5'd4,
      PH_BATCH_ATTR     = 5'd5,
      PH_LAST_DELTA     = 5'd6,
      PH_BASE_TS        = 5'd7,
      PH_MAX_TS         = 5'd8,
      PH_PRODUCER_ID    = 5'd9,
      PH_PRODUCER_EPOCH = 5'd10,
      PH_BASE_SEQ       = 5'd11,
      PH_REC_COUNT      = 5'd12,
      PH_REC_LEN        = 5'd13,
      PH_REC_ATTR       = 5'd14,
      PH_REC_TS         = 5'd15,
      PH_REC_OFF        = 5'd16,
      PH_KEY_LEN        = 5'd17,
      PH_KEY_BYTES      = 5'd18,
      PH_VAL_LEN        = 5'd19,
      PH_VAL_BYTES      = 5'd20,
      PH_HDR_COUNT      = 5'd21,
      PH_HK_LEN         = 5'd22,
      PH_HK_BYTES       = 5'd23,
      PH_HV_LEN         = 5'd24,
      PH_HV_BYTES       = 5'd25
   } phase_type;

   // result kinds
   localparam logic [4:0] K_BASE_OFFSET = 5'd0;
   localparam logic [4:0] K_BATCH_ATTR  = 5'd1;
   localparam logic [4:0] K_LAST_DELTA  = 5'd2;
   localparam logic [4:0] K_BASE_TS     = 5'd3;
   localparam logic [4:0] K_MAX_TS      = 5'd4;
   localparam logic [4:0] K_PRODUCER_ID = 5'd5;
   localparam logic [4:0] K_PROD_EPOCH  = 5'd6;
   localparam logic [4:0] K_BASE_SEQ    = 5'd7;
   localparam logic [4:0] K_REC_COUNT   = 5'd8;
   localparam logic [4:0] K_REC_ATTR    = 5'd9;
   localparam logic [4:0] K_TIMESTAMP   = 5'd10;
   localparam logic [4:0] K_OFFSET      = 5'd11;
   localparam logic [4:0] K_SEQUENCE    = 5'd12;
   localparam logic [4:0] K_KEY_LEN     = 5'd13;
   localparam logic [4:0] K_KEY_BYTE    = 5'd14;
   localparam logic [4:0] K_VAL_LEN     = 5'd15;
   localparam logic [4:0] K_VAL_BYTE    = 5'd16;
   localparam logic [4:0] K_HDR_COUNT   = 5'd17;
   localparam logic [4:0] K_HK_LEN      = 5'd18;
   localparam logic [4:0] K_HK_BYTE     = 5'd19;
   localparam logic [4:0] K_HV_LEN      = 5'd20;
   localparam logic [4:0] K_HV_BYTE     = 5'd21;
   localparam logic [4:0] K_DONE        = 5'd22;
   localparam logic [4:0] K_ERROR       = 5'd23;

   // error causes in check order
   localparam logic [3:0] E_SHORT        = 4'd0;
   localparam logic [3:0] E_NEG_BATCH    = 4'd1;
   localparam logic [3:0] E_BATCH_BEYOND = 4'd2;
   localparam logic [3:0] E_MAGIC        = 4'd3;
   localparam logic [3:0] E_COMPRESSED   = 4'd4;
   localparam logic [3:0] E_NEG_RECORDS  = 4'd5;
   localparam logic [3:0] E_NEG_REC_LEN  = 4'd6;
   localparam logic [3:0] E_VARINT       = 4'd7;
   localparam logic [3:0] E_REC_SIZE     = 4'd8;
   localparam logic [3:0] E_BATCH_SIZE   = 4'd9;
   localparam logic [3:0] E_TRAILING     = 4'd10;

   localparam logic [7:0] MAGIC_V2    = 8'h02;
   localparam logic [7:0] COMPR_MASK  = 8'h07;

   // parse state that does not scale with the length width
   typedef struct packed {
      phase_type    phase;
      logic [63:0]  acc;
      logic [6:0]   vshift;
      logic [3:0]   fdone;
      logic [63:0]  base_off;
      logic [63:0]  base_ts;
      logic [31:0]  base_seq;
      logic [30:0]  recs_left;
      logic [30:0]  rec_idx;
      logic [30:0]  hdr_left;
      logic [30:0]  pay_left;
      logic         finished;
   } st_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [63:0] value;
      logic [30:0] rec_num;
      logic [3:0]  err;
      logic        last;
   } res_type;

   // byte count of a fixed big-endian field, zero for others
   function automatic logic [3:0] fixed_size(phase_type ph);
      case (ph)
         PH_BASE_OFFSET, PH_BASE_TS, PH_MAX_TS, PH_PRODUCER_ID: return 4'd8;
         PH_BATCH_LEN, PH_LEADER_EPOCH, PH_CRC, PH_LAST_DELTA,
         PH_BASE_SEQ, PH_REC_COUNT:                             return 4'd4;
         PH_BATCH_ATTR, PH_PRODUCER_EPOCH:                      return 4'd2;
         PH_MAGIC, PH_REC_ATTR:                                 return 4'd1;
         default:                                               return 4'd0;
      endcase
   endfunction

   // width of a zigzag varint field, zero for others
   function automatic logic [6:0] varint_bits(phase_type ph);
      case (ph)
         PH_REC_TS, PH_REC_OFF:                          return 7'd64;
         PH_REC_LEN, PH_KEY_LEN, PH_VAL_LEN, PH_HDR_COUNT,
         PH_HK_LEN, PH_HV_LEN:                           return 7'd32;
         default:                                        return 7'd0;
      endcase
   endfunction

   function automatic res_type mk_res(logic [4:0] k, logic [63:0] v,
                                      logic [30:0] idx, logic [3:0] e);
      res_type r;
      r.kind    = k;
      r.value   = v;
      r.rec_num = (k >= K_REC_ATTR && k <= K_HV_BYTE) ? idx : 31'd0;
      r.err     = e;
      r.last    = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/rbp_step.sv -----
`timescale 1ns / 1ps
// Per-byte parse step: decodes one byte against the parse state and yields
// the next state plus up to three results. Depends on rbp_pkg.
module rbp_step
   import rbp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  st_type                 st,
   input  logic [LENGTH_BITS-1:0] pos,
   input  logic [LENGTH_BITS-1:0] total,
   input  logic [LENGTH_BITS:0]   batch_end,
   input  logic [LENGTH_BITS:0]   rec_end,
   input  logic [7:0]             data_byte,
   input  logic [31:0]            message_length,
   output st_type                 st_n,
   output logic [LENGTH_BITS-1:0] pos_n,
   output logic [LENGTH_BITS-1:0] total_n,
   output logic [LENGTH_BITS:0]   batch_end_n,
   output logic [LENGTH_BITS:0]   rec_end_n,
   output res_type [MAX_RES-1:0]  res,
   output logic [1:0]             res_cnt
);

   always_comb begin
      st_type                 n;
      logic [LENGTH_BITS-1:0] tot, np;
      logic [LENGTH_BITS:0]   be, re;
      logic [63:0]            len64, u, acc_f, acc_v, zz, end64, room, np64;
      logic [3:0]             fs;
      logic [6:0]             vb;
      logic [1:0]             cnt;
      logic                   do_field, adv, do_pd, do_rf, do_bf, sp;
      phase_type              pd_phase;
      logic [4:0]             sp_kind;
      res_type [MAX_RES-1:0]  r;

      n        = st;
      be       = batch_end;
      re       = rec_end;
      r        = '0;
      cnt      = 2'd0;
      do_field = 1'b0;
      adv      = 1'b0;
      do_pd    = 1'b0;
      do_rf    = 1'b0;
      do_bf    = 1'b0;
      sp       = 1'b0;
      sp_kind  = K_KEY_LEN;
      pd_phase = PH_KEY_BYTES;
      u        = '0;
      acc_f    = '0;
      acc_v    = '0;
      zz       = '0;
      end64    = '0;

      // sample the message length with the first byte, saturate, zero -> one
      len64 = {32'd0, message_length};
      if (pos == '0) begin
         if ((len64 >> LENGTH_BITS) != 64'd0) tot = '1;
         else tot = len64[LENGTH_BITS-1:0];
         if (tot == '0) tot = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      end else begin
         tot = total;
      end
      np   = pos + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      np64 = 64'(np);
      room = 64'(tot - np);
      fs   = fixed_size(st.phase);
      vb   = varint_bits(st.phase);

      if (!st.finished) begin
         // collect the byte into a fixed field, a varint or a payload run
         if (fs != 4'd0) begin
            acc_f   = {st.acc[55:0], data_byte};
            n.acc   = acc_f;
            n.fdone = st.fdone + 4'd1;
            if (n.fdone >= fs) begin
               case (fs)
                  4'd1:    u = {{56{acc_f[7]}}, acc_f[7:0]};
                  4'd2:    u = {{48{acc_f[15]}}, acc_f[15:0]};
                  4'd4:    u = {{32{acc_f[31]}}, acc_f[31:0]};
                  default: u = acc_f;
               endcase
               n.acc    = '0;
               n.fdone  = '0;
               do_field = 1'b1;
            end
         end else if (vb != 7'd0) begin
            if (st.vshift >= vb) begin
               r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_VARINT);
               cnt = cnt + 2'd1;
               n.finished = 1'b1;
            end else begin
               acc_v = st.acc | ({57'd0, data_byte[6:0]} << st.vshift[5:0]);
               if (vb != 7'd64) acc_v[63:32] = '0;
               n.acc = acc_v;
               if (data_byte[7]) begin
                  n.vshift = st.vshift + 7'd7;
               end else begin
                  zz = (acc_v >> 1) ^ {64{acc_v[0]}};
                  u  = (vb != 7'd64) ? {{32{zz[31]}}, zz[31:0]} : zz;
                  n.acc    = '0;
                  n.vshift = '0;
                  do_field = 1'b1;
               end
            end
         end else begin
            case (st.phase)
               PH_KEY_BYTES: r[cnt] = mk_res(K_KEY_BYTE, 64'(data_byte), st.rec_idx, '0);
               PH_VAL_BYTES: r[cnt] = mk_res(K_VAL_BYTE, 64'(data_byte), st.rec_idx, '0);
               PH_HK_BYTES:  r[cnt] = mk_res(K_HK_BYTE, 64'(data_byte), st.rec_idx, '0);
               default:      r[cnt] = mk_res(K_HV_BYTE, 64'(data_byte), st.rec_idx, '0);
            endcase
            cnt = cnt + 2'd1;
            n.pay_left = st.pay_left - 31'd1;
            if (n.pay_left == '0) begin
               do_pd    = 1'b1;
               pd_phase = st.phase;
            end
         end

         // act on a completed field
         if (do_field) begin
            adv = 1'b1;
            unique case (st.phase)
               PH_BASE_OFFSET: begin
                  n.base_off = u;
                  r[cnt] = mk_res(K_BASE_OFFSET, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_BATCH_LEN: begin
                  end64 = np64 + u;
                  if (u[63]) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_NEG_BATCH);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                     adv = 1'b0;
                  end else if (end64 > 64'(tot)) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_BATCH_BEYOND);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                     adv = 1'b0;
                  end else begin
                     be = end64[LENGTH_BITS:0];
                  end
               end
               PH_LEADER_EPOCH, PH_CRC: ;
               PH_MAGIC: begin
                  if (u != 64'(MAGIC_V2)) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_MAGIC);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                     adv = 1'b0;
                  end
               end
               PH_BATCH_ATTR: begin
                  if ((u[7:0] & COMPR_MASK) != 8'd0) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_COMPRESSED);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                     adv = 1'b0;
                  end else begin
                     r[cnt] = mk_res(K_BATCH_ATTR, u, st.rec_idx, '0);
                     cnt = cnt + 2'd1;
                  end
               end
               PH_LAST_DELTA: begin
                  r[cnt] = mk_res(K_LAST_DELTA, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_BASE_TS: begin
                  n.base_ts = u;
                  r[cnt] = mk_res(K_BASE_TS, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_MAX_TS: begin
                  r[cnt] = mk_res(K_MAX_TS, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_PRODUCER_ID: begin
                  r[cnt] = mk_res(K_PRODUCER_ID, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_PRODUCER_EPOCH: begin
                  r[cnt] = mk_res(K_PROD_EPOCH, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_BASE_SEQ: begin
                  n.base_seq = u[31:0];
                  r[cnt] = mk_res(K_BASE_SEQ, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_REC_COUNT: begin
                  adv = 1'b0;
                  if (u[63]) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_NEG_RECORDS);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                  end else begin
                     r[cnt] = mk_res(K_REC_COUNT, u, st.rec_idx, '0);
                     cnt = cnt + 2'd1;
                     n.recs_left = u[30:0];
                     n.rec_idx   = '0;
                     if (u[30:0] == '0) do_bf = 1'b1;
                     else n.phase = PH_REC_LEN;
                  end
               end
               PH_REC_LEN: begin
                  if (u[63]) begin
                     r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_NEG_REC_LEN);
                     cnt = cnt + 2'd1;
                     n.finished = 1'b1;
                     adv = 1'b0;
                  end else begin
                     end64 = np64 + u;
                     re = end64[LENGTH_BITS:0];
                  end
               end
               PH_REC_ATTR: begin
                  r[cnt] = mk_res(K_REC_ATTR, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_REC_TS: begin
                  r[cnt] = mk_res(K_TIMESTAMP, st.base_ts + u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_REC_OFF: begin
                  r[cnt] = mk_res(K_OFFSET, st.base_off + u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
                  r[cnt] = mk_res(K_SEQUENCE,
                     st.base_seq[31] ? 64'd0 : {33'd0, st.base_seq[30:0] + st.rec_idx},
                     st.rec_idx, '0);
                  cnt = cnt + 2'd1;
               end
               PH_KEY_LEN: begin sp = 1'b1; sp_kind = K_KEY_LEN; end
               PH_VAL_LEN: begin sp = 1'b1; sp_kind = K_VAL_LEN; end
               PH_HK_LEN:  begin sp = 1'b1; sp_kind = K_HK_LEN;  end
               PH_HV_LEN:  begin sp = 1'b1; sp_kind = K_HV_LEN;  end
               PH_HDR_COUNT: begin
                  adv = 1'b0;
                  r[cnt] = mk_res(K_HDR_COUNT, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
                  if (u[63] || u == 64'd0) begin
                     do_rf = 1'b1;
                  end else begin
                     n.hdr_left = u[30:0];
                     n.phase    = PH_HK_LEN;
                  end
               end
               default: begin
                  r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_SHORT);
                  cnt = cnt + 2'd1;
                  n.finished = 1'b1;
                  adv = 1'b0;
               end
            endcase

            // start a key, value or header payload
            if (sp) begin
               adv      = 1'b0;
               pd_phase = phase_type'(5'(st.phase) + 5'd1);
               if (u[63]) begin
                  r[cnt] = mk_res(sp_kind, '1, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
                  do_pd = 1'b1;
               end else if (u > room) begin
                  r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_SHORT);
                  cnt = cnt + 2'd1;
                  n.finished = 1'b1;
               end else begin
                  r[cnt] = mk_res(sp_kind, u, st.rec_idx, '0);
                  cnt = cnt + 2'd1;
                  if (u == 64'd0) begin
                     do_pd = 1'b1;
                  end else begin
                     n.pay_left = u[30:0];
                     n.phase    = pd_phase;
                  end
               end
            end
            if (adv) n.phase = phase_type'(5'(st.phase) + 5'd1);
         end

         // close a payload run
         if (do_pd) begin
            case (pd_phase)
               PH_KEY_BYTES: n.phase = PH_VAL_LEN;
               PH_VAL_BYTES: n.phase = PH_HDR_COUNT;
               PH_HK_BYTES:  n.phase = PH_HV_LEN;
               default: begin
                  n.hdr_left = n.hdr_left - 31'd1;
                  if (n.hdr_left == '0) do_rf = 1'b1;
                  else n.phase = PH_HK_LEN;
               end
            endcase
         end

         // close a record
         if (do_rf) begin
            if ({1'b0, np} != re) begin
               r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_REC_SIZE);
               cnt = cnt + 2'd1;
               n.finished = 1'b1;
            end else begin
               n.rec_idx   = n.rec_idx + 31'd1;
               n.recs_left = n.recs_left - 31'd1;
               if (n.recs_left == '0) do_bf = 1'b1;
               else n.phase = PH_REC_LEN;
            end
         end

         // close the batch
         if (do_bf) begin
            if ({1'b0, np} != be) begin
               r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_BATCH_SIZE);
            end else if (np != tot) begin
               r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_TRAILING);
            end else begin
               r[cnt] = mk_res(K_DONE, '0, st.rec_idx, '0);
            end
            cnt = cnt + 2'd1;
            n.finished = 1'b1;
         end

         // message ran out while the parse still needs bytes
         if (!n.finished && np == tot) begin
            r[cnt] = mk_res(K_ERROR, '0, st.rec_idx, E_SHORT);
            cnt = cnt + 2'd1;
            n.finished = 1'b1;
         end
      end

      // restart the parse at the end of each message
      if (np == tot || np == '0) begin
         st_n        = '0;
         pos_n       = '0;
         total_n     = '0;
         batch_end_n = '0;
         rec_end_n   = '0;
      end else begin
         st_n        = n;
         pos_n       = np;
         total_n     = tot;
         batch_end_n = be;
         rec_end_n   = re;
      end
      res     = r;
      res_cnt = cnt;
   end

endmodule

// ----- rtl/rbp_rsp_fifo.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle, hands out one per
// transaction and marks the last of each group. Depends on rbp_pkg.
module rbp_rsp_fifo
   import rbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  res_type [MAX_RES-1:0] push_res,
   input  logic [1:0]            push_cnt,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output res_type               rsp_res
);

   res_type              mem [RSP_DEPTH];
   logic [RSP_PTR_W:0]   cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic                 pop;

   // pointer and fill bookkeeping
   always_comb begin
      pop    = (cnt_ff != '0) && !rsp_stall;
      rd_in  = rd_ff + RSP_PTR_W'(pop);
      wr_in  = wr_ff + RSP_PTR_W'(push_cnt);
      cnt_in = cnt_ff + (RSP_PTR_W+1)'(push_cnt) - (RSP_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
         wr_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   // store the group, flag its last entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push_cnt) begin
            mem[wr_ff + RSP_PTR_W'(i)] <= '{kind: push_res[i].kind,
                                           value: push_res[i].value,
                                           rec_num: push_res[i].rec_num,
                                           err: push_res[i].err,
                                           last: (2'(i) == push_cnt - 2'd1)};
         end
      end
   end

   assign room      = cnt_ff <= (RSP_PTR_W+1)'(RSP_DEPTH - MAX_RES);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_res   = mem[rd_ff];

endmodule

// ----- rtl/record_batch_v2_parser.sv -----
`timescale 1ns / 1ps
// Record batch v2 parser top level: input register, parse step, result queue.
// A byte waits in the input register until the queue has room for its results.
// Throughput: one byte per cycle while the queue has room; the queue hands out
// one result per transaction, so bytes with two or three results can fill it.
// Reset: synchronous, active high; clears the parse state and the queue.
module record_batch_v2_parser
   import rbp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_result_kind,
   output logic signed [63:0] rsp_result_value,
   output logic [30:0] rsp_record_number,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_run_last
);

   logic                   in_v_ff;
   logic [7:0]             byte_ff;
   logic [31:0]            len_ff;
   st_type                 st_ff, st_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in, total_ff, total_in;
   logic [LENGTH_BITS:0]   bend_ff, bend_in, rend_ff, rend_in;
   res_type [MAX_RES-1:0]  step_res;
   logic [1:0]             step_cnt, push_cnt;
   logic                   room, advance;
   res_type                out_res;

   assign advance   = in_v_ff && room;
   assign req_stall = in_v_ff && !room;
   assign push_cnt  = advance ? step_cnt : 2'd0;

   // hold the transaction until the queue has room for its results
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_v_ff <= 1'b1;
      end else if (advance) begin
         in_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_data_byte;
         len_ff  <= req_message_length;
      end
   end

   rbp_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .st             (st_ff),
      .pos            (pos_ff),
      .total          (total_ff),
      .batch_end      (bend_ff),
      .rec_end        (rend_ff),
      .data_byte      (byte_ff),
      .message_length (len_ff),
      .st_n           (st_in),
      .pos_n          (pos_in),
      .total_n        (total_in),
      .batch_end_n    (bend_in),
      .rec_end_n      (rend_in),
      .res            (step_res),
      .res_cnt        (step_cnt)
   );

   // advance the parse state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= '0;
         pos_ff   <= '0;
         total_ff <= '0;
         bend_ff  <= '0;
         rend_ff  <= '0;
      end else if (advance) begin
         st_ff    <= st_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         bend_ff  <= bend_in;
         rend_ff  <= rend_in;
      end
   end

   rbp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_res  (step_res),
      .push_cnt  (push_cnt),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (out_res)
   );

   assign rsp_result_kind   = out_res.kind;
   assign rsp_result_value  = out_res.value;
   assign rsp_record_number = out_res.rec_num;
   assign rsp_error_code    = out_res.err;
   assign rsp_run_last      = out_res.last;

endmodule

// ----- bench/record_batch_v2_parser_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the record batch v2 parser: builds whole batch
// messages (good and broken), predicts every result and compares field by field.
// Depends on rbp_pkg and record_batch_v2_parser.
module record_batch_v2_parser_test
   import rbp_pkg::*;
();

   typedef enum int {
      MSG_GOOD, MSG_TRUNC, MSG_MAGIC, MSG_COMPRESS, MSG_NEG_BATCH, MSG_BEYOND,
      MSG_NEG_COUNT, MSG_NEG_RLEN, MSG_VARINT, MSG_RSIZE, MSG_BSIZE, MSG_TRAIL,
      MSG_KEY_SHORT, MSG_NOISE
   } msg_shape_type;

   typedef struct {
      logic [7:0]  data;
      logic [31:0] len;
   } stream_byte_type;

   // bytes per fixed field and bit width per varint field, indexed by phase
   localparam int FIELD_BYTES [26] = '{8, 4, 4, 1, 4, 2, 4, 8, 8, 8, 2, 4, 4,
                                       0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   localparam int VARINT_WIDTH [26] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                        32, 0, 64, 64, 32, 0, 32, 0, 32, 32, 0, 32, 0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic [31:0] req_message_length = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_result_kind;
   logic signed [63:0] rsp_result_value;
   logic [30:0] rsp_record_number;
   logic [3:0]  rsp_error_code;
   logic        rsp_run_last;

   record_batch_v2_parser u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_message_length(req_message_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_result_value(rsp_result_value),
      .rsp_record_number(rsp_record_number), .rsp_error_code(rsp_error_code),
      .rsp_run_last(rsp_run_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stream_byte_type byte_stream [$];
   res_type     parse_results [$];
   logic [7:0]  msg [$];
   logic [7:0]  body [$];
   logic [7:0]  rec [$];
   int          mismatches = 0;
   int          bytes_taken = 0;
   bit          req_taken = 1'b0;
   bit          calm;
   stream_byte_type next_byte;

   // parser shadow state
   phase_type   sh_phase;
   logic [63:0] sh_pos, sh_total, sh_acc, sh_base_off, sh_base_ts, sh_bend, sh_rend;
   int          sh_vshift, sh_fdone, sh_count;
   logic [31:0] sh_base_seq;
   logic [30:0] sh_recs_left, sh_rec_idx, sh_hdr_left, sh_pay_left;
   bit          sh_finished;

   task automatic report(input string what);
      if (mismatches < 40) $display("ERROR %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // append helpers for the byte queues
   function automatic void put_msg(logic [7:0] b);
      msg.insert(msg.size(), b);
   endfunction

   function automatic void put_body(logic [7:0] b);
      body.insert(body.size(), b);
   endfunction

   function automatic void put_rec(logic [7:0] b);
      rec.insert(rec.size(), b);
   endfunction

   function automatic void put_stream(stream_byte_type s);
      byte_stream.insert(byte_stream.size(), s);
   endfunction

   // ---------------- prediction ----------------
   function automatic void clear_parse();
      sh_phase = PH_BASE_OFFSET;
      sh_pos = '0; sh_total = '0; sh_acc = '0; sh_vshift = 0; sh_fdone = 0;
      sh_base_off = '0; sh_base_ts = '0; sh_base_seq = '0; sh_bend = '0; sh_rend = '0;
      sh_recs_left = '0; sh_rec_idx = '0; sh_hdr_left = '0; sh_pay_left = '0;
      sh_finished = 1'b0;
   endfunction

   function automatic logic [63:0] sign_fit(logic [63:0] v, int bits);
      logic [63:0] m;
      if (bits >= 64) return v;
      m = 64'd1 << (bits - 1);
      v &= (64'd1 << bits) - 64'd1;
      return (v ^ m) - m;
   endfunction

   function automatic void add_result(logic [4:0] k, logic [63:0] v, logic [3:0] e);
      res_type r;
      if (sh_count >= MAX_RES) return;
      r.kind = k;
      r.value = v;
      r.rec_num = (k >= K_REC_ATTR && k <= K_HV_BYTE) ? sh_rec_idx : 31'd0;
      r.err = e;
      r.last = 1'b0;
      parse_results.insert(parse_results.size(), r);
      sh_count++;
   endfunction

   function automatic void abort_parse(logic [3:0] code);
      add_result(K_ERROR, 64'd0, code);
      sh_finished = 1'b1;
   endfunction

   function automatic void close_batch();
      if (sh_pos != sh_bend) abort_parse(E_BATCH_SIZE);
      else if (sh_pos != sh_total) abort_parse(E_TRAILING);
      else begin
         add_result(K_DONE, 64'd0, '0);
         sh_finished = 1'b1;
      end
   endfunction

   function automatic void close_record();
      if (sh_pos != sh_rend) begin
         abort_parse(E_REC_SIZE);
         return;
      end
      sh_rec_idx = sh_rec_idx + 31'd1;
      sh_recs_left = sh_recs_left - 31'd1;
      if (sh_recs_left == 0) close_batch();
      else sh_phase = PH_REC_LEN;
   endfunction

   function automatic void close_payload(phase_type p);
      case (p)
         PH_KEY_BYTES: sh_phase = PH_VAL_LEN;
         PH_VAL_BYTES: sh_phase = PH_HDR_COUNT;
         PH_HK_BYTES:  sh_phase = PH_HV_LEN;
         default: begin
            sh_hdr_left = sh_hdr_left - 31'd1;
            if (sh_hdr_left == 0) close_record();
            else sh_phase = PH_HK_LEN;
         end
      endcase
   endfunction

   function automatic void open_payload(logic [63:0] v, logic [4:0] k);
      phase_type bp;
      bp = phase_type'(5'(sh_phase) + 5'd1);
      if (v[63]) begin
         add_result(k, '1, '0);
         close_payload(bp);
      end else if (v > sh_total - sh_pos) begin
         abort_parse(E_SHORT);
      end else begin
         add_result(k, v, '0);
         if (v == 0) close_payload(bp);
         else begin
            sh_pay_left = v[30:0];
            sh_phase = bp;
         end
      end
   endfunction

   function automatic void field_complete(logic [63:0] v);
      logic [63:0] seq;
      case (sh_phase)
         PH_BASE_OFFSET: begin sh_base_off = v; add_result(K_BASE_OFFSET, v, '0); end
         PH_BATCH_LEN: begin
            if (v[63]) begin abort_parse(E_NEG_BATCH); return; end
            if (sh_pos + v > sh_total) begin abort_parse(E_BATCH_BEYOND); return; end
            sh_bend = sh_pos + v;
         end
         PH_LEADER_EPOCH, PH_CRC: ;
         PH_MAGIC: if (v != 64'(MAGIC_V2)) begin abort_parse(E_MAGIC); return; end
         PH_BATCH_ATTR: begin
            if ((v & 64'(COMPR_MASK)) != 0) begin abort_parse(E_COMPRESSED); return; end
            add_result(K_BATCH_ATTR, v, '0);
         end
         PH_LAST_DELTA: add_result(K_LAST_DELTA, v, '0);
         PH_BASE_TS: begin sh_base_ts = v; add_result(K_BASE_TS, v, '0); end
         PH_MAX_TS: add_result(K_MAX_TS, v, '0);
         PH_PRODUCER_ID: add_result(K_PRODUCER_ID, v, '0);
         PH_PRODUCER_EPOCH: add_result(K_PROD_EPOCH, v, '0);
         PH_BASE_SEQ: begin sh_base_seq = v[31:0]; add_result(K_BASE_SEQ, v, '0); end
         PH_REC_COUNT: begin
            if (v[63]) begin abort_parse(E_NEG_RECORDS); return; end
            add_result(K_REC_COUNT, v, '0);
            sh_recs_left = v[30:0];
            sh_rec_idx = '0;
            if (sh_recs_left == 0) close_batch();
            else sh_phase = PH_REC_LEN;
            return;
         end
         PH_REC_LEN: begin
            if (v[63]) begin abort_parse(E_NEG_REC_LEN); return; end
            sh_rend = sh_pos + v;
         end
         PH_REC_ATTR: add_result(K_REC_ATTR, v, '0);
         PH_REC_TS: add_result(K_TIMESTAMP, sh_base_ts + v, '0);
         PH_REC_OFF: begin
            add_result(K_OFFSET, sh_base_off + v, '0);
            seq = sh_base_seq[31] ? 64'd0
                : ((64'(sh_base_seq) + 64'(sh_rec_idx)) & 64'h7fff_ffff);
            add_result(K_SEQUENCE, seq, '0);
         end
         PH_KEY_LEN: begin open_payload(v, K_KEY_LEN); return; end
         PH_VAL_LEN: begin open_payload(v, K_VAL_LEN); return; end
         PH_HDR_COUNT: begin
            add_result(K_HDR_COUNT, v, '0);
            if (v[63] || v == 0) close_record();
            else begin
               sh_hdr_left = v[30:0];
               sh_phase = PH_HK_LEN;
            end
            return;
         end
         PH_HK_LEN: begin open_payload(v, K_HK_LEN); return; end
         PH_HV_LEN: begin open_payload(v, K_HV_LEN); return; end
         default: begin abort_parse(E_SHORT); return; end
      endcase
      sh_phase = phase_type'(5'(sh_phase) + 5'd1);
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int fs, vb;
      logic [63:0] u;
      fs = FIELD_BYTES[sh_phase];
      vb = VARINT_WIDTH[sh_phase];
      if (fs != 0) begin
         sh_acc = (sh_acc << 8) | 64'(b);
         sh_fdone++;
         if (sh_fdone < fs) return;
         u = sign_fit(sh_acc, fs * 8);
         sh_acc = '0;
         sh_fdone = 0;
         field_complete(u);
      end else if (vb != 0) begin
         if (sh_vshift >= vb) begin abort_parse(E_VARINT); return; end
         sh_acc |= 64'(b & 8'h7f) << sh_vshift;
         if (vb < 64) sh_acc &= (64'd1 << vb) - 64'd1;
         if (b[7]) begin sh_vshift += 7; return; end
         u = (sh_acc >> 1) ^ (64'd0 - (sh_acc & 64'd1));
         u = sign_fit(u, vb);
         sh_acc = '0;
         sh_vshift = 0;
         field_complete(u);
      end else begin
         add_result(sh_phase == PH_KEY_BYTES ? K_KEY_BYTE : sh_phase == PH_VAL_BYTES ?
                    K_VAL_BYTE : sh_phase == PH_HK_BYTES ? K_HK_BYTE : K_HV_BYTE,
                    64'(b), '0);
         sh_pay_left = sh_pay_left - 31'd1;
         if (sh_pay_left == 0) close_payload(sh_phase);
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic [31:0] len);
      sh_count = 0;
      if (sh_pos == 0) sh_total = (len == 0) ? 64'd1 : 64'(len);
      sh_pos = (sh_pos + 64'd1) & 64'hffff_ffff;
      if (!sh_finished) begin
         take_byte(b);
         if (!sh_finished && sh_pos == sh_total) abort_parse(E_SHORT);
      end
      if (sh_pos == sh_total || sh_pos == 0) clear_parse();
      if (sh_count > 0) parse_results[parse_results.size() - 1].last = 1'b1;
   endfunction

   // ---------------- message building ----------------
   function automatic logic [63:0] rand_wide();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 300));
         1: return -64'($urandom_range(1, 300));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void put_be(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) put_msg(v[i*8 +: 8]);
   endfunction

   // zigzag then base-128 little-endian groups
   function automatic void put_varint(logic [63:0] v, int bits, bit to_body);
      logic [63:0] z;
      logic [7:0] b;
      if (bits == 32) z = 64'((v[31:0] << 1) ^ {32{v[31]}});
      else z = (v << 1) ^ {64{v[63]}};
      do begin
         b = {1'b0, z[6:0]};
         z = z >> 7;
         if (z != 0) b[7] = 1'b1;
         if (to_body) put_body(b);
         else put_rec(b);
      end while (z != 0);
   endfunction

   function automatic int pick_len();
      case ($urandom_range(0, 7))
         0: return -1;
         1: return -$urandom_range(2, 100000);
         2: return 0;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic void put_payload(int n);
      put_varint(64'(signed'(n)), 32, 1'b0);
      for (int i = 0; i < n; i++) put_rec(8'($urandom));
   endfunction

   function automatic void add_record(msg_shape_type shape);
      int n, hc;
      rec.delete();
      put_rec(8'($urandom));
      if (shape == MSG_VARINT) begin
         repeat (10) put_rec(8'h80);
         put_rec(8'h00);
      end else put_varint(rand_wide(), 64, 1'b0);
      put_varint(rand_wide(), 64, 1'b0);
      if (shape == MSG_KEY_SHORT) put_varint(64'd5000, 32, 1'b0);
      else put_payload(pick_len());
      put_payload(pick_len());
      case ($urandom_range(0, 4))
         0: hc = -1;
         1: hc = -$urandom_range(2, 50);
         2: hc = 0;
         default: hc = $urandom_range(1, 2);
      endcase
      put_varint(64'(signed'(hc)), 32, 1'b0);
      for (int h = 0; h < hc; h++) begin
         put_payload(pick_len());
         put_payload(pick_len());
      end
      n = rec.size();
      if (shape == MSG_RSIZE) n = $urandom_range(0, 1) ? n + 1 : n - 1;
      if (shape == MSG_NEG_RLEN) n = -$urandom_range(1, 1000);
      put_varint(64'(signed'(n)), 32, 1'b1);
      foreach (rec[i]) put_body(rec[i]);
   endfunction

   function automatic void queue_message();
      stream_byte_type s;
      foreach (msg[i]) begin
         s.data = msg[i];
         s.len = (i == 0) ? 32'(msg.size()) : $urandom;
         put_stream(s);
      end
   endfunction

   function automatic void build_batch(msg_shape_type shape);
      int nrec, blen, cut;
      logic [31:0] seq;
      body.delete();
      msg.delete();
      nrec = $urandom_range(0, 3);
      if (shape inside {MSG_NEG_RLEN, MSG_VARINT, MSG_RSIZE, MSG_KEY_SHORT} && nrec == 0)
         nrec = 1;
      for (int r = 0; r < nrec; r++) add_record(r == nrec - 1 ? shape : MSG_GOOD);
      blen = 49 + body.size();
      if (shape == MSG_TRAIL) repeat ($urandom_range(1, 4)) put_body(8'($urandom));
      if (shape == MSG_BSIZE) blen = blen - 1;
      if (shape == MSG_BEYOND) blen = blen + $urandom_range(1, 100);
      if (shape == MSG_NEG_BATCH) blen = $urandom | 32'h8000_0000;
      case ($urandom_range(0, 3))
         0: seq = $urandom | 32'h8000_0000;
         1: seq = 32'h7fff_ffff - $urandom_range(0, 2);
         default: seq = $urandom_range(0, 1000);
      endcase
      put_be(rand_wide(), 8);
      put_be(64'(blen), 4);
      put_be(64'($urandom), 4);
      put_be(shape == MSG_MAGIC ? 64'($urandom_range(3, 255)) : 64'(MAGIC_V2), 1);
      put_be(64'($urandom), 4);
      put_be(shape == MSG_COMPRESS ? 64'($urandom | 1) : 64'($urandom & 16'hfff8), 2);
      put_be(64'($urandom), 4);
      put_be(rand_wide(), 8);
      put_be(rand_wide(), 8);
      put_be(rand_wide(), 8);
      put_be(64'($urandom), 2);
      put_be(64'(seq), 4);
      put_be(shape == MSG_NEG_COUNT ? 64'($urandom | 32'h8000_0000) : 64'(nrec), 4);
      foreach (body[i]) put_msg(body[i]);
      if (shape == MSG_TRUNC) begin
         cut = $urandom_range(1, msg.size() - 1);
         while (msg.size() > cut) void'(msg.pop_back());
      end
      if (shape == MSG_NOISE) begin
         msg.delete();
         repeat ($urandom_range(1, 40)) put_msg(8'($urandom));
      end
      queue_message();
   endfunction

   // ---------------- driver ----------------
   // hold a stalled transaction, otherwise advance or idle
   always @(negedge clock) begin
      calm = bytes_taken >= 150 && bytes_taken < 320;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (byte_stream.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
            next_byte = byte_stream.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_byte.data;
            req_message_length <= next_byte.len;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < 8);
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            bytes_taken++;
            predict_byte(req_data_byte, req_message_length);
         end
         if (rsp_valid && !rsp_stall) begin
            if (parse_results.size() == 0) begin
               report($sformatf("unexpected result kind %0d value %0h",
                                rsp_result_kind, rsp_result_value));
            end else begin
               res_type e;
               e = parse_results.pop_front();
               if (rsp_result_kind !== e.kind || rsp_result_value !== e.value ||
                   rsp_record_number !== e.rec_num || rsp_error_code !== e.err ||
                   rsp_run_last !== e.last)
                  report($sformatf({"got kind %0d value %h rec %0d err %0d last %0b, ",
                                    "want kind %0d value %h rec %0d err %0d last %0b"},
                                   rsp_result_kind, rsp_result_value, rsp_record_number,
                                   rsp_error_code, rsp_run_last, e.kind, e.value,
                                   e.rec_num, e.err, e.last));
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      int queued;
      msg_shape_type shape;
      stream_byte_type lone;
      clear_parse();
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // zero length taken as one, then a two-byte message ending early
      lone.data = 8'hff;
      lone.len  = 32'd0;
      put_stream(lone);
      msg.delete(); put_msg(8'h00); put_msg(8'hff);
      queue_message();
      build_batch(MSG_GOOD);
      build_batch(MSG_MAGIC);

      // drain completely before the random part
      while (byte_stream.size() > 0 || req_valid || parse_results.size() > 0)
         @(posedge clock);

      queued = 0;
      while (queued < 460) begin
         if ($urandom_range(0, 99) < 55) shape = MSG_GOOD;
         else shape = msg_shape_type'($urandom_range(1, 13));
         build_batch(shape);
         queued += msg.size();
      end

      while (byte_stream.size() > 0 || req_valid || parse_results.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (parse_results.size() > 0)
         report($sformatf("%0d results never arrived", parse_results.size()));
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
